>>> rtl/pes_pkg.sv
// Package for the periodic event scheduler.
// Holds the item kind codes, the classified operation codes and the command
// structure passed between the front and back parts. Depends on nothing.
package pes_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_MODE = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REG  = 2'd1,
    OP_MODE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] period;
    logic [2:0]  slot;
    logic        enable;
  } cmd_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

>>> rtl/periodic_event_scheduler.sv
// Periodic event scheduler: a table of up to SLOTS periodic timers driven by a
// 32-bit tick counter that each tick item advances. An item is taken when start
// is high and busy is low; busy rises only when the two-entry command queue is
// full. Each item gives one result beat, shown for one cycle with out_valid
// high; the receiver cannot hold a beat off and must take it in the cycle it is
// shown. A register or disable item is answered straight from the idle state
// once it leaves the queue, an enable item first passes a mode state that sets
// the slot's next due time, and a tick walks the slot table through its single
// read port one slot per cycle. Results come out in the order the items were
// taken.
// Depends on pes_pkg, pes_front and pes_back.
module periodic_event_scheduler #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_period,
  input  logic [2:0]  in_slot,
  input  logic        in_enable,
  output logic        out_valid,
  output logic [7:0]  out_fire_mask,
  output logic [2:0]  out_assigned_slot,
  output logic        out_accepted
);

  logic          q_valid;
  logic          q_pop;
  pes_pkg::cmd_t q_cmd;

  pes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_kind   (in_kind),
    .in_period (in_period),
    .in_slot   (in_slot),
    .in_enable (in_enable),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  pes_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_fire_mask     (out_fire_mask),
    .out_assigned_slot (out_assigned_slot),
    .out_accepted      (out_accepted)
  );

endmodule

>>> rtl/pes_front.sv
// Front part of the periodic event scheduler: accepts items, classifies them
// and holds them in a two-entry command queue for the back part.
// Depends on pes_pkg.
module pes_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_kind,
  input  logic [31:0]   in_period,
  input  logic [2:0]    in_slot,
  input  logic          in_enable,
  output logic          q_valid,
  output pes_pkg::cmd_t q_cmd,
  input  logic          q_pop
);

  localparam int CNT_W = $clog2(pes_pkg::QUEUE_DEPTH + 1);

  pes_pkg::cmd_t q_r [pes_pkg::QUEUE_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic          push;
  pes_pkg::cmd_t new_cmd;

  assign busy    = (cnt_r == CNT_W'(pes_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.period = in_period;
    new_cmd.slot   = in_slot;
    new_cmd.enable = in_enable;
    unique case (in_kind)
      pes_pkg::KIND_TICK: new_cmd.op = pes_pkg::OP_TICK;
      pes_pkg::KIND_REG:  new_cmd.op = pes_pkg::OP_REG;
      pes_pkg::KIND_MODE: new_cmd.op = pes_pkg::OP_MODE;
      default:            new_cmd.op = pes_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

>>> rtl/pes_back.sv
// Back part of the periodic event scheduler: executes queued commands against
// the slot table, walking the slots one per cycle on a tick.
// Depends on pes_pkg.
module pes_back #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  pes_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  output logic [7:0]    out_fire_mask,
  output logic [2:0]    out_assigned_slot,
  output logic          out_accepted
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_MODE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOTS-1:0] en_r, en_nxt;
  logic [IDX_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [7:0]       mask_r, mask_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_fire_mask_r, out_fire_mask_nxt;
  logic [2:0]       out_assigned_slot_r, out_assigned_slot_nxt;
  logic             out_accepted_r, out_accepted_nxt;

  logic [31:0]      reload_mem [SLOTS];
  logic [31:0]      due_mem [SLOTS];
  logic [31:0]      reload_q, due_q;

  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             reload_we, due_we;
  logic [31:0]      reload_wdata, due_wdata;
  logic             slot_ok, table_full, issue;
  logic [IDX_W-1:0] cmd_idx;

  assign cmd_idx    = q_cmd.slot[IDX_W-1:0];
  assign slot_ok    = ({1'b0, q_cmd.slot} < 4'(cnt_r));
  assign table_full = (cnt_r >= CNT_W'(SLOTS));
  assign issue      = (rd_cnt_r < cnt_r);

  always_comb begin
    state_nxt             = state_r;
    now_nxt               = now_r;
    cnt_nxt               = cnt_r;
    en_nxt                = en_r;
    cur_slot_nxt          = cur_slot_r;
    rd_cnt_nxt            = rd_cnt_r;
    chk_v_nxt             = 1'b0;
    chk_idx_nxt           = chk_idx_r;
    mask_nxt              = mask_r;
    out_valid_nxt         = 1'b0;
    out_fire_mask_nxt     = out_fire_mask_r;
    out_assigned_slot_nxt = out_assigned_slot_r;
    out_accepted_nxt      = out_accepted_r;
    q_pop                 = 1'b0;
    rd_addr               = rd_cnt_r[IDX_W-1:0];
    wr_addr               = cur_slot_r;
    reload_we             = 1'b0;
    due_we                = 1'b0;
    reload_wdata          = q_cmd.period - 32'd1;
    due_wdata             = now_r + q_cmd.period;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop                 = 1'b1;
          out_fire_mask_nxt     = 8'd0;
          out_assigned_slot_nxt = 3'd0;
          out_accepted_nxt      = 1'b0;
          unique case (q_cmd.op)
            pes_pkg::OP_TICK: begin
              now_nxt    = now_r + 32'd1;
              rd_cnt_nxt = '0;
              mask_nxt   = 8'd0;
              state_nxt  = ST_WALK;
            end
            pes_pkg::OP_REG: begin
              out_valid_nxt = 1'b1;
              if (!table_full) begin
                wr_addr               = cnt_r[IDX_W-1:0];
                reload_we             = 1'b1;
                due_we                = 1'b1;
                en_nxt[cnt_r[IDX_W-1:0]] = 1'b0;
                cnt_nxt               = cnt_r + CNT_W'(1);
                out_assigned_slot_nxt = 3'(cnt_r);
                out_accepted_nxt      = 1'b1;
              end
            end
            pes_pkg::OP_MODE: begin
              if (slot_ok) begin
                en_nxt[cmd_idx] = q_cmd.enable;
                if (q_cmd.enable) begin
                  rd_addr      = cmd_idx;
                  cur_slot_nxt = cmd_idx;
                  state_nxt    = ST_MODE;
                end else begin
                  out_valid_nxt    = 1'b1;
                  out_accepted_nxt = 1'b1;
                end
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (issue) begin
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
        end
        if (chk_v_r && en_r[chk_idx_r] && (due_q == now_r)) begin
          wr_addr   = chk_idx_r;
          due_we    = 1'b1;
          due_wdata = now_r + reload_q;
          mask_nxt  = mask_r | (8'd1 << chk_idx_r);
        end
        if (!issue && !chk_v_r) begin
          out_valid_nxt     = 1'b1;
          out_fire_mask_nxt = mask_r;
          out_accepted_nxt  = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_MODE: begin
        wr_addr          = cur_slot_r;
        due_we           = 1'b1;
        due_wdata        = now_r + reload_q;
        out_valid_nxt    = 1'b1;
        out_accepted_nxt = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= 32'd0;
      cnt_r       <= '0;
      en_r        <= '0;
      rd_cnt_r    <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      cnt_r       <= cnt_nxt;
      en_r        <= en_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_slot_r          <= cur_slot_nxt;
    chk_idx_r           <= chk_idx_nxt;
    mask_r              <= mask_nxt;
    out_fire_mask_r     <= out_fire_mask_nxt;
    out_assigned_slot_r <= out_assigned_slot_nxt;
    out_accepted_r      <= out_accepted_nxt;
  end

  always_ff @(posedge clk) begin
    if (reload_we) begin
      reload_mem[wr_addr] <= reload_wdata;
    end
    if (due_we) begin
      due_mem[wr_addr] <= due_wdata;
    end
    reload_q <= reload_mem[rd_addr];
    due_q    <= due_mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_fire_mask     = out_fire_mask_r;
  assign out_assigned_slot = out_assigned_slot_r;
  assign out_accepted      = out_accepted_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= SLOTS)
    else $error("slot count exceeds table size");

  a_mode_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODE) |=> (out_valid_r && out_accepted_r && (state_r == ST_IDLE)))
    else $error("enable command did not complete in one cycle");

  a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_fire_mask_r >> cnt_r) == 8'd0))
    else $error("fire mask names an unregistered slot");

  a_chk_live: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (int'(chk_idx_r) < int'(cnt_r)))
    else $error("walk checked a slot beyond the count");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_fire_mask_r != 8'd0)) |-> out_accepted_r)
    else $error("fired slots reported on a refused beat");

endmodule

>>> tb/sv/periodic_event_scheduler_test.sv
// Self-checking testbench for periodic_event_scheduler: a tracker class predicts
// each result beat from the accepted items, and plain tasks drive the block.
// Depends on pes_pkg and the periodic_event_scheduler RTL.
module periodic_event_scheduler_test;

  localparam int SLOTS = 8;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] fire_mask;
    logic [2:0] assigned_slot;
    logic       accepted;
  } beat_t;

  class timer_table_tracker;
    logic [31:0] now_tick;
    int unsigned used_slots;
    bit          slot_on [SLOTS];
    logic [31:0] slot_reload [SLOTS];
    logic [31:0] slot_due [SLOTS];
    beat_t       expected_beats [$];
    int unsigned errors, items, ticks, firings, refusals;

    function new();
      now_tick = '0;
      used_slots = 0;
      foreach (slot_on[i]) begin
        slot_on[i] = 1'b0;
        slot_reload[i] = '0;
        slot_due[i] = '0;
      end
      errors = 0;
      items = 0;
      ticks = 0;
      firings = 0;
      refusals = 0;
    endfunction

    function int unsigned waiting();
      return expected_beats.size();
    endfunction

    function void predict_item(logic [1:0] kind, logic [31:0] period, logic [2:0] slot,
                               logic enable);
      beat_t want;
      want = '0;
      items++;
      case (kind)
        pes_pkg::KIND_TICK: begin
          now_tick = now_tick + 32'd1;
          for (int i = 0; i < used_slots; i++) begin
            if (slot_on[i] && slot_due[i] == now_tick) begin
              slot_due[i] = now_tick + slot_reload[i];
              want.fire_mask[i] = 1'b1;
              firings++;
            end
          end
          want.accepted = 1'b1;
          ticks++;
        end
        pes_pkg::KIND_REG: begin
          if (used_slots < SLOTS) begin
            slot_on[used_slots] = 1'b0;
            slot_reload[used_slots] = period - 32'd1;
            slot_due[used_slots] = now_tick + period;
            want.assigned_slot = 3'(used_slots);
            want.accepted = 1'b1;
            used_slots++;
          end else begin
            refusals++;
          end
        end
        pes_pkg::KIND_MODE: begin
          if (slot < used_slots) begin
            slot_on[slot] = enable;
            if (enable) slot_due[slot] = now_tick + slot_reload[slot];
            want.accepted = 1'b1;
          end else begin
            refusals++;
          end
        end
        default: ;
      endcase
      expected_beats.push_back(want);
    endfunction

    function void check_beat(logic [7:0] mask, logic [2:0] assigned, logic acc);
      beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: fire_mask %02h assigned_slot %0d accepted %0b",
               mask, assigned, acc);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (mask !== want.fire_mask) begin
        $error("fire_mask: expected %02h, got %02h", want.fire_mask, mask);
        errors++;
      end
      if (assigned !== want.assigned_slot) begin
        $error("assigned_slot: expected %0d, got %0d", want.assigned_slot, assigned);
        errors++;
      end
      if (acc !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, acc);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [31:0] in_period;
  logic [2:0]  in_slot;
  logic        in_enable;
  logic        out_valid;
  logic [7:0]  out_fire_mask;
  logic [2:0]  out_assigned_slot;
  logic        out_accepted;

  timer_table_tracker tracker;

  periodic_event_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_period(in_period),
    .in_slot(in_slot),
    .in_enable(in_enable),
    .out_valid(out_valid),
    .out_fire_mask(out_fire_mask),
    .out_assigned_slot(out_assigned_slot),
    .out_accepted(out_accepted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("periodic_event_scheduler regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_beat(out_fire_mask, out_assigned_slot, out_accepted);
      if (start && !busy) tracker.predict_item(in_kind, in_period, in_slot, in_enable);
    end
  end

  task automatic send_item(logic [1:0] kind, logic [31:0] period, logic [2:0] slot,
                           logic enable);
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_period <= period;
    in_slot <= slot;
    in_enable <= enable;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      in_kind <= 2'($urandom);
      in_period <= $urandom;
      in_slot <= 3'($urandom);
      in_enable <= 1'($urandom);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  kind;
    pick = $urandom_range(0, 99);
    if (pick < 60) kind = pes_pkg::KIND_TICK;
    else if (pick < 85) kind = pes_pkg::KIND_MODE;
    else if (pick < 92) kind = pes_pkg::KIND_REG;
    else kind = KIND_UNUSED;
    send_item(kind, $urandom, 3'($urandom_range(0, SLOTS - 1)), $urandom_range(0, 9) < 6);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    tracker = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = pes_pkg::KIND_TICK;
    in_period = '0;
    in_slot = '0;
    in_enable = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: a tick, a refused mode beat and an unused kind with every field high.
    send_item(pes_pkg::KIND_TICK, 32'd0, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_MODE, 32'd0, 3'd0, 1'b1);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_item(pes_pkg::KIND_REG, 32'd0, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_REG, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_item(pes_pkg::KIND_MODE, 32'd0, 3'd2, 1'b1);
    send_item(pes_pkg::KIND_REG, 32'd2, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_REG, 32'd3, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_REG, 32'd4, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_REG, 32'd5, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_REG, 32'd7, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_REG, $urandom_range(2, 9), 3'd0, 1'b0);
    // The table is now full, so this registration must be refused.
    send_item(pes_pkg::KIND_REG, 32'd9, 3'd0, 1'b0);
    for (int i = 0; i < SLOTS; i++) send_item(pes_pkg::KIND_MODE, 32'd0, 3'(i), 1'b1);
    send_item(pes_pkg::KIND_TICK, 32'd0, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_TICK, 32'd0, 3'd0, 1'b0);
    send_item(pes_pkg::KIND_MODE, 32'd0, 3'd2, 1'b0);
    send_item(pes_pkg::KIND_TICK, 32'd0, 3'd0, 1'b0);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
        send_random_item();
        sent++;
        if (sent % 200 == 0) drain_results();
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
    end

    drain_results();
    repeat (SLOTS + 12) @(posedge clk);
    tracker.errors += tracker.waiting();
    $display("Ran %0d items: %0d ticks with %0d slot firings, %0d refused commands.",
             tracker.items, tracker.ticks, tracker.firings, tracker.refusals);
    if (tracker.errors == 0) begin
      $display("periodic_event_scheduler regression: pass");
    end else begin
      $display("periodic_event_scheduler regression: fail");
    end
    $finish;
  end

endmodule
